// ===== sv/spicl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the sample player voice.
// No dependencies; used by spicl_ctrl, spicl_dp and the top level.
package spicl_pkg;

	// operation codes carried on s_tuser
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
	localparam logic [OP_W-1:0] OP_TICK    = 3'd1;
	localparam logic [OP_W-1:0] OP_PLAY    = 3'd2;
	localparam logic [OP_W-1:0] OP_PAUSE   = 3'd3;
	localparam logic [OP_W-1:0] OP_UNPAUSE = 3'd4;
	localparam logic [OP_W-1:0] OP_STOP    = 3'd5;
	localparam logic [OP_W-1:0] OP_SEEK    = 3'd6;

	// configuration register indexes
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 20;
	localparam logic [REG_IDX_W-1:0] REG_RATE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SPEED  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_VOLUME = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CUE_IN = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CUE_OUT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LOOP   = 3'd5;

	// reset values and clamps
	localparam logic [19:0]        RATE_RST    = 20'd65536;
	localparam logic signed [16:0] SPEED_RST   = 17'sd4096;
	localparam logic signed [16:0] SPEED_MAX   = 17'sd40960;   // +10.0 in Q4.12
	localparam logic signed [16:0] SPEED_MIN   = -17'sd40960;  // -10.0 in Q4.12
	localparam logic [15:0]        VOLUME_MAX  = 16'd32768;
	localparam logic [15:0]        CUE_OUT_RST = 16'd65533;

	// playhead integer part, and the reported position width
	localparam int POS_INT_W = 18;
	localparam int POS_OUT_W = 17;

	typedef struct packed {
		logic apply;    // input beat accepted: run write / control op
		logic rd_en;    // store read
		logic rd_next;  // read at n+1 instead of n
		logic cap_a;    // capture first sample
		logic mul;      // interpolation and increment products
		logic interp;   // form interpolated value
		logic vol;      // volume product
		logic fin;      // update playhead, load result
		logic active;   // tick inside window while playing
	} cmd_t;

	typedef struct packed {
		logic active;   // playing and playhead inside window
	} st_t;

endpackage

// ===== sv/spicl_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the sample player: handshakes and tick steps.
// Depends on spicl_pkg.
module spicl_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [spicl_pkg::OP_W-1:0]    op,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output spicl_pkg::cmd_t               cmd,
	input  spicl_pkg::st_t                st
);
	import spicl_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EVAL   = 3'd1;
	localparam logic [2:0] S_RDB    = 3'd2;
	localparam logic [2:0] S_MUL    = 3'd3;
	localparam logic [2:0] S_INTERP = 3'd4;
	localparam logic [2:0] S_VOL    = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0] state_q, state_nxt;
	logic       active_q;
	logic       m_tvalid_q;
	logic       out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		cmd.active  = active_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.apply = 1'b1;
					if (op == OP_TICK) state_nxt = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.rd_en = 1'b1;
				state_nxt = st.active ? S_RDB : S_FIN;
			end
			S_RDB: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_next = 1'b1;
				cmd.cap_a   = 1'b1;
				state_nxt   = S_MUL;
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = S_INTERP;
			end
			S_INTERP: begin
				cmd.interp = 1'b1;
				state_nxt  = S_VOL;
			end
			S_VOL: begin
				cmd.vol   = 1'b1;
				state_nxt = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.fin   = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			active_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_EVAL) active_q <= st.active;
			if (cmd.fin) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/spicl_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the sample player: sample store, playhead, config registers,
// interpolation and volume arithmetic, result register. Depends on spicl_pkg.
module spicl_dp #(
	parameter int SAMPLE_DEPTH  = 65536,
	parameter int SAMPLE_WIDTH  = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  spicl_pkg::cmd_t                      cmd,
	output spicl_pkg::st_t                       st,
	input  logic [spicl_pkg::OP_W-1:0]           op,
	input  logic [15:0]                          address,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
	input  logic [15:0]                          position,
	input  logic                                 cfg_we,
	input  logic [spicl_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [spicl_pkg::CFG_W-1:0]          cfg_data,
	output logic signed [SAMPLE_WIDTH-1:0]       audio_out,
	output logic                                 finished,
	output logic                                 playing_now,
	output logic signed [spicl_pkg::POS_OUT_W-1:0] position_now
);
	import spicl_pkg::*;

	localparam int ADDR_W    = $clog2(SAMPLE_DEPTH);
	localparam int POS_W     = FRACTION_BITS + POS_INT_W;
	localparam int INC_SHIFT = 28 - FRACTION_BITS;
	localparam int SW        = SAMPLE_WIDTH;
	localparam int VW        = SAMPLE_WIDTH + FRACTION_BITS + 2;
	localparam int AW        = SAMPLE_WIDTH + 18;
	localparam logic [VW-1:0] HALF = VW'(1) << (FRACTION_BITS - 1);
	localparam logic signed [SW+2:0] A_MAX = (SW+3)'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [SW+2:0] A_MIN = -A_MAX - (SW+3)'(1);
	localparam logic signed [AW-1:0] VOL_RND = AW'(16384);

	// configuration
	logic [19:0]        rate_q;
	logic signed [16:0] speed_q;
	logic [15:0]        volume_q;
	logic [15:0]        cue_in_q;
	logic [15:0]        cue_out_q;
	logic               loop_q;
	logic signed [16:0] spd_w;
	logic [15:0]        vol_w;

	// play state
	logic signed [POS_W-1:0] pos_q, pos_nxt;
	logic playing_q, was_playing_q, armed_q;

	// store
	logic signed [SW-1:0] mem [SAMPLE_DEPTH];
	logic signed [SW-1:0] rd_data_q;
	logic                 rd_ok_q;
	logic [16:0]          rd_idx;
	logic                 rd_ok, wr_ok;
	logic signed [SW-1:0] samp;

	// arithmetic
	logic signed [POS_INT_W-1:0] n, n_nxt;
	logic [FRACTION_BITS-1:0]    f;
	logic signed [POS_INT_W:0]   n_x, lo_x, hi_x;
	logic signed [SW-1:0]        a_s1;
	logic signed [SW:0]          diff;
	logic signed [VW-1:0]        iprod, prod_s2, a_w, vsum;
	logic signed [37:0]          rprod;
	logic signed [POS_W-1:0]     inc_s2;
	logic signed [SW-1:0]        v_s3;
	logic signed [SW+16:0]       vprod, vp_s4;
	logic signed [AW-1:0]        a_rnd;
	logic signed [SW+2:0]        a_sh;
	logic signed [SW-1:0]        a_sat;
	logic [15:0]                 back_idx;

	logic signed [SW-1:0]        audio_q;
	logic                        finished_q, playing_now_q;
	logic signed [POS_OUT_W-1:0] position_now_q;

	function automatic logic signed [POS_W-1:0] idx_pos(input logic [15:0] i);
		idx_pos = {2'b00, i, {FRACTION_BITS{1'b0}}};
	endfunction

	assign audio_out    = audio_q;
	assign finished     = finished_q;
	assign playing_now  = playing_now_q;
	assign position_now = position_now_q;

	// playhead decode and window test
	assign n    = pos_q[POS_W-1:FRACTION_BITS];
	assign f    = pos_q[FRACTION_BITS-1:0];
	assign n_x  = {n[POS_INT_W-1], n};
	assign lo_x = $signed({3'b000, cue_in_q});
	assign hi_x = $signed({3'b000, cue_out_q}) - $signed((POS_INT_W+1)'(1));
	assign st.active = playing_q && (n_x >= lo_x) && (n_x < hi_x);

	// config write with clamps
	assign spd_w = $signed(cfg_data[16:0]);
	assign vol_w = cfg_data[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= RATE_RST;
			speed_q   <= SPEED_RST;
			volume_q  <= VOLUME_MAX;
			cue_in_q  <= '0;
			cue_out_q <= CUE_OUT_RST;
			loop_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RATE:    rate_q <= cfg_data[19:0];
				REG_SPEED: begin
					if (spd_w > SPEED_MAX) speed_q <= SPEED_MAX;
					else if (spd_w < SPEED_MIN) speed_q <= SPEED_MIN;
					else speed_q <= spd_w;
				end
				REG_VOLUME:  volume_q <= (vol_w > VOLUME_MAX) ? VOLUME_MAX : vol_w;
				REG_CUE_IN:  cue_in_q <= cfg_data[15:0];
				REG_CUE_OUT: cue_out_q <= cfg_data[15:0];
				REG_LOOP:    loop_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sample store, one write and one registered read per cycle
	assign rd_idx = n[16:0] + {16'b0, cmd.rd_next};
	assign rd_ok  = {15'b0, rd_idx} < 32'(SAMPLE_DEPTH);
	assign wr_ok  = {16'b0, address} < 32'(SAMPLE_DEPTH);
	assign samp   = rd_ok_q ? rd_data_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.apply && op == OP_WRITE && wr_ok) mem[ADDR_W'(address)] <= sample_in;
		if (cmd.rd_en) begin
			rd_data_q <= mem[ADDR_W'(rd_idx)];
			rd_ok_q   <= rd_ok;
		end
	end

	// interpolation: a*2^F + (b-a)*f + half, then volume
	assign diff  = {samp[SW-1], samp} - {a_s1[SW-1], a_s1};
	assign iprod = diff * $signed({1'b0, f});
	assign rprod = $signed({1'b0, rate_q}) * speed_q;
	assign a_w   = VW'(a_s1);
	assign vsum  = (a_w <<< FRACTION_BITS) + prod_s2 + $signed(HALF);
	assign vprod = v_s3 * $signed({1'b0, volume_q});
	assign a_rnd = AW'(vp_s4) + VOL_RND;
	assign a_sh  = $signed(a_rnd[AW-1:15]);

	always_comb begin
		if (a_sh > A_MAX) a_sat = SW'(A_MAX);
		else if (a_sh < A_MIN) a_sat = SW'(A_MIN);
		else a_sat = a_sh[SW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_a) a_s1 <= samp;
		if (cmd.mul) begin
			prod_s2 <= iprod;
			inc_s2  <= POS_W'(rprod >>> INC_SHIFT);
		end
		if (cmd.interp) v_s3 <= vsum[FRACTION_BITS +: SW];
		if (cmd.vol) vp_s4 <= vprod;
	end

	// playhead after a tick
	assign back_idx = (cue_out_q < 16'd2) ? 16'd0 : cue_out_q - 16'd2;

	always_comb begin
		pos_nxt = pos_q;
		if (cmd.active) pos_nxt = pos_q + inc_s2;
		else if (playing_q && loop_q) begin
			if (speed_q < 0) pos_nxt = idx_pos(back_idx);
			else if (speed_q > 0) pos_nxt = idx_pos(cue_in_q);
		end
	end
	assign n_nxt = pos_nxt[POS_W-1:FRACTION_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			playing_q     <= 1'b0;
			was_playing_q <= 1'b0;
			armed_q       <= 1'b0;
		end else if (cmd.apply) begin
			case (op)
				OP_PLAY: begin
					playing_q     <= 1'b1;
					was_playing_q <= 1'b1;
					armed_q       <= 1'b1;
					pos_q         <= idx_pos(cue_in_q);
				end
				OP_PAUSE:   playing_q <= 1'b0;
				OP_UNPAUSE: if (was_playing_q) playing_q <= 1'b1;
				OP_STOP: begin
					playing_q     <= 1'b0;
					was_playing_q <= 1'b0;
					pos_q         <= idx_pos(cue_in_q);
				end
				OP_SEEK:    pos_q <= idx_pos(position);
				default: ;
			endcase
		end else if (cmd.fin) begin
			pos_q <= pos_nxt;
			if (!cmd.active && playing_q) armed_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			audio_q       <= cmd.active ? a_sat : '0;
			finished_q    <= !cmd.active && playing_q && armed_q;
			playing_now_q <= playing_q;
			if (n_nxt > 18'sd65535) position_now_q <= 17'sd65535;
			else if (n_nxt < -18'sd65536) position_now_q <= -17'sd65536;
			else position_now_q <= n_nxt[POS_OUT_W-1:0];
		end
	end

endmodule

// ===== sv/sample_player_interp_cue_loop_top.sv =====
`timescale 1ns / 1ps
// Top level of the mono sample player voice with linear interpolation and cue window.
// Depends on spicl_pkg, spicl_ctrl and spicl_dp.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | op on tuser; address, sample_in, position
//  m_*     | out       | m_tvalid/m_tready  | audio_out, finished, playing_now, position_now
//  cfg_*   | in        | cfg_we             | register index and data, no wait
//
// Write, play, pause, unpause, stop and seek beats give no result. A tick
// inside the window runs two reads of the sample store (samples n and
// n+1), then the interpolation product, the interpolated value and the
// volume product, one register stage each, then the result.
// A tick that is idle or outside the window goes straight to the result.
// No new beat is taken until a tick has loaded its result. The result sits
// in an output register; the next input beat is accepted while it waits.
// A tick that finds that register still full holds in its last step until
// m_tready frees it.
// Reset (arst_n low) clears the play state and loads the default registers;
// the sample store is not cleared and must be written before it is played.
module sample_player_interp_cue_loop_top #(
	parameter int SAMPLE_DEPTH  = 65536,
	parameter int SAMPLE_WIDTH  = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// address, sample_in, position
	input  logic [((SAMPLE_WIDTH+32+7)/8)*8-1:0]   s_tdata,
	// op
	input  logic [spicl_pkg::OP_W-1:0]             s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// audio_out, finished, playing_now, position_now
	output logic [((SAMPLE_WIDTH+19+7)/8)*8-1:0]   m_tdata,
	input  logic                                   cfg_we,
	input  logic [spicl_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [spicl_pkg::CFG_W-1:0]            cfg_data
);
	import spicl_pkg::*;

	localparam int OUT_W = ((SAMPLE_WIDTH + 19 + 7) / 8) * 8;

	cmd_t cmd;
	st_t  st;

	logic signed [SAMPLE_WIDTH-1:0] audio_out;
	logic                           finished;
	logic                           playing_now;
	logic signed [POS_OUT_W-1:0]    position_now;

	spicl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

	spicl_dp #(
		.SAMPLE_DEPTH  (SAMPLE_DEPTH),
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.op           (s_tuser),
		.address      (s_tdata[15:0]),
		.sample_in    (s_tdata[16 +: SAMPLE_WIDTH]),
		.position     (s_tdata[16+SAMPLE_WIDTH +: 16]),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.audio_out    (audio_out),
		.finished     (finished),
		.playing_now  (playing_now),
		.position_now (position_now)
	);

	// fields packed from bit 0 up
	assign m_tdata = OUT_W'({position_now, playing_now, finished, audio_out});

	// the finish beat is always a silent one
	a_finish_silent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[SAMPLE_WIDTH] |-> m_tdata[SAMPLE_WIDTH-1:0] == '0)
		else $error("finished beat carries nonzero audio");

	// no sound while not playing
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[SAMPLE_WIDTH+1] |-> m_tdata[SAMPLE_WIDTH-1:0] == '0)
		else $error("audio while not playing");

	// a tick occupies the sequencer
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_TICK |=> !s_tready)
		else $error("input taken during tick");

endmodule
